// ===== rtl/spd_pkg.sv =====
// Package with the shared constants, types and helper function of the sensor packet deframer.
package spd_pkg;

    localparam int unsigned FRAME_BODY = 22;
    localparam int unsigned IDX_W = 5;
    localparam logic [IDX_W-1:0] CHECKSUM_IDX = IDX_W'(FRAME_BODY);
    localparam logic [7:0] SYNC_RESET = 8'hFF;
    localparam int unsigned OUT_DATA_W = 88;

    localparam logic [1:0] CLASS_BLACK = 2'd0;
    localparam logic [1:0] CLASS_WHITE = 2'd1;
    localparam logic [1:0] CLASS_GREEN = 2'd2;
    localparam logic [1:0] CLASS_BLUE  = 2'd3;

    typedef logic [FRAME_BODY-1:0][7:0] body_t;

    typedef struct packed {
        logic        start_pulse;
        logic [1:0]  zone_class;
        logic [1:0]  right_class;
        logic [1:0]  left_class;
        logic [15:0] flow_dy;
        logic [15:0] flow_dx;
        logic [15:0] range_c_mm;
        logic [15:0] range_b_mm;
        logic [15:0] range_a_mm;
    } result_t;

    function automatic logic [1:0] colour_class(input logic [7:0] code);
        logic [1:0] cls;
        case (code)
            8'd1:    cls = CLASS_WHITE;
            8'd2:    cls = CLASS_GREEN;
            8'd3:    cls = CLASS_BLUE;
            default: cls = CLASS_BLACK;
        endcase
        return cls;
    endfunction

endpackage

// ===== rtl/spd_byte_cell.sv =====
// One byte cell of the frame shift chain, loading its neighbor's byte on each shift.
module spd_byte_cell
    import spd_pkg::*;
(
    input  logic       clk,
    input  logic       shift,
    input  logic [7:0] din,
    output logic [7:0] dout
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    assign byte_next = shift ? din : byte_reg;
    assign dout      = byte_reg;

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

endmodule

// ===== rtl/spd_frame_decode.sv =====
// Field extraction and colour zone logic over the filled frame cells.
module spd_frame_decode
    import spd_pkg::*;
(
    input  body_t   body,
    input  logic    start_latched,
    output result_t fields
);

    // Byte j of the frame sits in cell FRAME_BODY-1-j once the chain is full.
    function automatic logic [15:0] le16(input body_t b, input int unsigned pos);
        return {b[FRAME_BODY - 2 - pos], b[FRAME_BODY - 1 - pos]};
    endfunction

    logic [1:0] left_cls;
    logic [1:0] right_cls;
    logic [1:0] zone_cls;
    logic [7:0] start_flag;

    assign left_cls   = colour_class(body[FRAME_BODY - 1 - 19]);
    assign right_cls  = colour_class(body[FRAME_BODY - 1 - 20]);
    assign start_flag = body[FRAME_BODY - 1 - 21];

    always_comb
    begin
        if (left_cls == right_cls && left_cls != CLASS_BLACK)
        begin
            zone_cls = left_cls;
        end
        else if (left_cls == CLASS_WHITE || right_cls == CLASS_WHITE)
        begin
            zone_cls = CLASS_WHITE;
        end
        else
        begin
            zone_cls = CLASS_BLACK;
        end
    end

    always_comb
    begin
        fields.range_a_mm  = le16(body, 9);
        fields.range_b_mm  = le16(body, 11);
        fields.range_c_mm  = le16(body, 13);
        fields.flow_dx     = le16(body, 15);
        fields.flow_dy     = le16(body, 17);
        fields.left_class  = left_cls;
        fields.right_class = right_cls;
        fields.zone_class  = zone_cls;
        fields.start_pulse = (start_flag != 8'd0) && !start_latched;
    end

endmodule

// ===== rtl/sensor_packet_deframer_top.sv =====
// Top level of the sensor packet deframer: sync hunt, byte shift chain, checksum and output register.
//
// Channel   Direction  Width  Contents
// s_axis    in         8      tdata: rx_byte
// m_axis    out        88+1   tdata: ranges, flows, classes, start_pulse; tuser: frame_status
// cfg       in         8      cfg_data: sync_value
//
// A byte can be accepted in every cycle unless the output register stalls the input.
// The result of a frame appears in the cycle after its checksum byte is accepted.
// The single output register stalls the input only while a result waits and m_tready is low.
// Reset clears the hunt state, byte count, checksum, start latch and output valid;
// the sync value returns to 0xFF.
module sensor_packet_deframer_top
    import spd_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [7:0] rx_byte
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // [15:0] range_a_mm, [31:16] range_b_mm, [47:32] range_c_mm, [63:48] flow_dx,
    // [79:64] flow_dy, [81:80] left_class, [83:82] right_class, [85:84] zone_class,
    // [86] start_pulse, [87] zero.
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,   // [0] frame_status
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [7:0]            cfg_data
);

    logic [7:0]       sync_reg;
    logic             hunting_reg;
    logic             hunting_next;
    logic [IDX_W-1:0] byte_idx_reg;
    logic [IDX_W-1:0] byte_idx_next;
    logic [7:0]       xor_reg;
    logic [7:0]       xor_next;
    logic             latched_reg;
    logic             latched_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    result_t          out_data_reg;
    result_t          out_data_next;
    logic             out_status_reg;
    logic             out_status_next;

    logic    accept;
    logic    is_sync;
    logic    is_checksum;
    logic    shift;
    logic    good;
    body_t   body;
    result_t fields;

    assign cfg_ready   = 1'b1;
    assign s_tready    = !out_valid_reg || m_tready;
    assign accept      = s_tvalid && s_tready;
    assign is_sync     = hunting_reg && (s_tdata == sync_reg);
    assign is_checksum = !hunting_reg && (byte_idx_reg == CHECKSUM_IDX);
    assign shift       = accept && (is_sync || (!hunting_reg && !is_checksum));
    assign good        = (xor_reg == s_tdata);

    genvar gi;
    generate
        for (gi = 0; gi < FRAME_BODY; gi++)
        begin : g_chain
            if (gi == 0)
            begin : g_head
                spd_byte_cell u_cell (
                    .clk  (clk),
                    .shift(shift),
                    .din  (s_tdata),
                    .dout (body[gi])
                );
            end
            else
            begin : g_link
                spd_byte_cell u_cell (
                    .clk  (clk),
                    .shift(shift),
                    .din  (body[gi-1]),
                    .dout (body[gi])
                );
            end
        end
    endgenerate

    spd_frame_decode u_decode (
        .body         (body),
        .start_latched(latched_reg),
        .fields       (fields)
    );

    always_comb
    begin
        hunting_next    = hunting_reg;
        byte_idx_next   = byte_idx_reg;
        xor_next        = xor_reg;
        latched_next    = latched_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_data_next   = out_data_reg;
        out_status_next = out_status_reg;
        if (accept)
        begin
            if (hunting_reg)
            begin
                if (is_sync)
                begin
                    hunting_next  = 1'b0;
                    byte_idx_next = IDX_W'(1);
                    xor_next      = s_tdata;
                end
            end
            else if (is_checksum)
            begin
                hunting_next   = 1'b1;
                byte_idx_next  = '0;
                xor_next       = 8'd0;
                out_valid_next = 1'b1;
                if (good)
                begin
                    out_data_next   = fields;
                    out_status_next = 1'b0;
                    latched_next    = latched_reg || fields.start_pulse;
                end
                else
                begin
                    out_data_next   = '0;
                    out_status_next = 1'b1;
                end
            end
            else
            begin
                byte_idx_next = byte_idx_reg + IDX_W'(1);
                xor_next      = xor_reg ^ s_tdata;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg      <= SYNC_RESET;
            hunting_reg   <= 1'b1;
            byte_idx_reg  <= '0;
            xor_reg       <= 8'd0;
            latched_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                sync_reg <= cfg_data;
            end
            hunting_reg   <= hunting_next;
            byte_idx_reg  <= byte_idx_next;
            xor_reg       <= xor_next;
            latched_reg   <= latched_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg   <= out_data_next;
        out_status_reg <= out_status_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {1'b0, out_data_reg};

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        byte_idx_reg <= CHECKSUM_IDX)
        else $error("byte index past the checksum position");

    a_hunt_idx: assert property (@(posedge clk) disable iff (!rst_n)
        hunting_reg |-> byte_idx_reg == '0 && xor_reg == 8'd0)
        else $error("hunting with a partial frame in progress");

    a_latch_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(latched_reg) |-> out_valid_reg && out_data_reg.start_pulse && !out_status_reg)
        else $error("start latch set without a start pulse result");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_status_reg |-> out_data_reg == '0)
        else $error("checksum error result carries nonzero fields");

    a_result_close: assert property (@(posedge clk) disable iff (!rst_n)
        accept && is_checksum |=> out_valid_reg && hunting_reg)
        else $error("checksum byte did not close the frame");

endmodule
